// File: src/ics_pkg.sv
`timescale 1ns / 1ps

package ics_pkg;

    // Item geometry: eight bytes per beat, paired into 16-bit words
    localparam int DATA_W         = 64;
    localparam int BYTES_PER_ITEM = DATA_W / 8;
    localparam int WORDS_PER_ITEM = BYTES_PER_ITEM / 2;
    localparam int COUNT_W        = 4;
    localparam int WORD_W         = 16;
    localparam int PART_W         = WORD_W + $clog2(WORDS_PER_ITEM);
    localparam int SUM_W          = 32;

    // Depth of the queue between front and back end
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    // Reset value of the byte order register
    localparam logic NETWORK_ORDER_RESET = 1'b1;

    // One classified item: partial word sum of the beat plus end-of-buffer mark
    typedef struct packed {
        logic [PART_W-1:0] part_sum;
        logic              last;
    } ics_item_t;

endpackage

// File: src/ics_front.sv
`timescale 1ns / 1ps

module ics_front
    import ics_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [DATA_W-1:0]  data_bytes,
    input  logic [COUNT_W-1:0] valid_bytes,
    input  logic               last,
    output logic               push,
    output ics_item_t          push_item,
    input  logic               queue_full
);

    logic                          network_order_reg;
    logic [COUNT_W-1:0]            count;
    logic [WORDS_PER_ITEM-1:0][WORD_W-1:0] words;
    logic [PART_W-1:0]             part_sum;

    // Byte order register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            network_order_reg <= NETWORK_ORDER_RESET;
        end
        else if (cfg_write_en)
        begin
            network_order_reg <= cfg_write_data;
        end
    end

    // Saturate the byte count to the beat width
    always_comb
    begin
        if (valid_bytes > COUNT_W'(BYTES_PER_ITEM))
        begin
            count = COUNT_W'(BYTES_PER_ITEM);
        end
        else
        begin
            count = valid_bytes;
        end
    end

    // Pair bytes into words; bytes past the count read as zero
    always_comb
    begin
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        for (int p = 0; p < WORDS_PER_ITEM; p++)
        begin
            first_byte  = (COUNT_W'(2 * p) < count) ? data_bytes[16*p +: 8] : 8'h00;
            second_byte = (COUNT_W'(2 * p + 1) < count) ? data_bytes[16*p+8 +: 8] : 8'h00;
            if (network_order_reg)
            begin
                words[p] = {first_byte, second_byte};
            end
            else
            begin
                words[p] = {second_byte, first_byte};
            end
        end
    end

    // Sum the words of the beat; no carry is lost at this width
    always_comb
    begin
        part_sum = '0;
        for (int p = 0; p < WORDS_PER_ITEM; p++)
        begin
            part_sum = part_sum + PART_W'(words[p]);
        end
    end

    // Hand the classified beat to the queue
    assign in_stall           = queue_full;
    assign push               = in_valid && !queue_full;
    assign push_item.part_sum = part_sum;
    assign push_item.last     = last;

endmodule

// File: src/ics_queue.sv
`timescale 1ns / 1ps

module ics_queue
    import ics_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ics_item_t push_item,
    output logic      full,
    output logic      pop_valid,
    output ics_item_t pop_item,
    input  logic      pop
);

    ics_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Fill count stays within the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    // A push into a full queue would overwrite an entry
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push while queue full");

    // Push without pop raises the fill count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fill count did not follow a push");

endmodule

// File: src/ics_back.sv
`timescale 1ns / 1ps

module ics_back
    import ics_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    input  ics_item_t   pop_item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] checksum
);

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              fold_valid_reg;
    logic [SUM_W-1:0]  fold_sum_reg;
    logic              out_valid_reg;
    logic [15:0]       checksum_reg;
    logic              out_free;
    logic              fold_move;
    logic              fold_free;
    logic [WORD_W:0]   fold_once;
    logic [WORD_W:0]   fold_twice;

    // Handshake between the stages of the back end
    assign out_free  = !out_valid_reg || !out_stall;
    assign fold_move = fold_valid_reg && out_free;
    assign fold_free = !fold_valid_reg || fold_move;
    assign pop       = pop_valid && (!pop_item.last || fold_free);

    // Running sum wraps at 32 bits
    assign sum_next = sum_reg + SUM_W'(pop_item.part_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (pop)
        begin
            sum_reg <= pop_item.last ? '0 : sum_next;
        end
    end

    // Fold stage: holds the buffer total until the output register is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
        end
        else if (pop && pop_item.last)
        begin
            fold_valid_reg <= 1'b1;
        end
        else if (fold_move)
        begin
            fold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_item.last)
        begin
            fold_sum_reg <= sum_next;
        end
    end

    // Two end-around folds to 16 bits
    assign fold_once  = {1'b0, fold_sum_reg[SUM_W-1:WORD_W]} + {1'b0, fold_sum_reg[WORD_W-1:0]};
    assign fold_twice = {1'b0, fold_once[WORD_W-1:0]} + (WORD_W + 1)'(fold_once[WORD_W]);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fold_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fold_move)
        begin
            checksum_reg <= ~fold_twice[WORD_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

    // Running sum starts afresh after every end of buffer
    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_item.last) |=> sum_reg == '0)
        else $error("running sum not cleared after last transfer");

    // A waiting total is neither lost nor altered
    a_fold_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fold_valid_reg && !out_free) |=> fold_valid_reg && $stable(fold_sum_reg))
        else $error("fold stage lost its total under stall");

    // A last item never enters while the fold stage is blocked
    a_fold_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_item.last) |-> fold_free)
        else $error("fold stage overrun");

endmodule

// File: src/internet_checksum_stream.sv
`timescale 1ns / 1ps

// Streaming Internet checksum (ones complement sum of 16-bit words). Each input
// transfer carries up to eight bytes, byte 0 in the low bits, and is paired into
// words from byte 0 upward; network_order (reset 1) makes the first byte of each
// pair the high byte, 0 makes it the low byte. An odd trailing byte is padded
// with a zero second byte. The block takes one transfer per cycle while in_stall
// is low: the front end sums the beat's words combinationally into a two-entry
// queue; the back end adds one entry per cycle, bar a last entry that meets a
// busy fold stage, into the 32-bit running sum, the rate-setting loop. On a last
// transfer the total is folded to 16 bits, inverted and registered onto checksum,
// and the running sum clears. Write network_order only while the block is idle.

module internet_checksum_stream
    import ics_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [DATA_W-1:0]  data_bytes,
    input  logic [COUNT_W-1:0] valid_bytes,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        checksum
);

    logic      push;
    ics_item_t push_item;
    logic      queue_full;
    logic      pop_valid;
    ics_item_t pop_item;
    logic      pop;

    ics_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_bytes     (data_bytes),
        .valid_bytes    (valid_bytes),
        .last           (last),
        .push           (push),
        .push_item      (push_item),
        .queue_full     (queue_full)
    );

    ics_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop)
    );

    ics_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .checksum  (checksum)
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ics_pkg::*;

    localparam int SETTLE_CYCLES = 8;     // covers the two-stage path plus the queue
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int STALL_LIMIT   = 2000;  // cycles without any transfer before giving up

    // Mid-phase pressure actions
    typedef enum int {PRESS_NONE, PRESS_DRAIN, PRESS_HOLD} press_t;

    // Expected checksums, worked out from every accepted input transfer
    class checksum_scoreboard;
        logic [SUM_W-1:0] running_sum;
        logic             network_order;
        logic [15:0]      expected_sums[$];
        int               errors;

        function new();
            running_sum   = '0;
            network_order = NETWORK_ORDER_RESET;
            errors        = 0;
        endfunction

        function void set_order(logic order);
            network_order = order;
        endfunction

        function void note_transfer(logic [DATA_W-1:0] d, logic [COUNT_W-1:0] n, logic l);
            int               count;
            logic [7:0]       first_byte;
            logic [7:0]       second_byte;
            logic [15:0]      word;
            logic [SUM_W-1:0] folded;
            // counts above the beat width saturate
            count = (n > BYTES_PER_ITEM) ? BYTES_PER_ITEM : int'(n);
            // pair from byte 0 upward; a lone trailing byte gets a zero partner
            for (int i = 0; i < count; i += 2)
            begin
                first_byte  = d[8*i +: 8];
                second_byte = (i + 1 < count) ? d[8*(i+1) +: 8] : 8'h00;
                word = network_order ? {first_byte, second_byte}
                                     : {second_byte, first_byte};
                running_sum += SUM_W'(word);
            end
            // fold twice, invert, clear
            if (l)
            begin
                folded = (running_sum >> 16) + (running_sum & 32'h0000_ffff);
                folded += folded >> 16;
                expected_sums.push_back(~folded[15:0]);
                running_sum = '0;
            end
        endfunction

        function void check_checksum(logic [15:0] got);
            logic [15:0] want;
            if (expected_sums.size() == 0)
            begin
                $display("%0t: unexpected checksum transfer, expected none, actual %h",
                         $time, got);
                errors++;
            end
            else
            begin
                want = expected_sums.pop_front();
                if (got !== want)
                begin
                    $display("%0t: checksum mismatch, expected %h, actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic               cfg_write_data;
    logic               in_valid;
    logic               in_stall;
    logic [DATA_W-1:0]  data_bytes;
    logic [COUNT_W-1:0] valid_bytes;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        checksum;

    checksum_scoreboard sb;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int hold_seen;
    int hold_left;
    int items_sent;
    int idle_cycles;

    internet_checksum_stream dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_bytes     (data_bytes),
        .valid_bytes    (valid_bytes),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .checksum       (checksum)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off counted here on request
    initial
    begin
        out_stall <= 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result check, sampled mid-cycle once everything has settled
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_checksum(checksum);
    end

    // Watchdog: give up after too long without any transfer on either side
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Offer one transfer and hold it until accepted; returns on the accepting edge
    task automatic send_item(input logic [DATA_W-1:0] d, input logic [COUNT_W-1:0] n,
                             input logic l);
        logic accepted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_bytes  <= d;
        valid_bytes <= n;
        last        <= l;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = !in_stall;
            @(posedge clk);
        end
        sb.note_transfer(d, n, l);
        items_sent++;
    endtask

    // Sender pause until every expected checksum has come back
    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_sums.size() != 0)
            @(posedge clk);
    endtask

    // Byte order write, only once the block has gone quiet
    task automatic write_order(input logic order);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= order;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.set_order(order);
    endtask

    function automatic logic [DATA_W-1:0] random_data();
        case ($urandom_range(7))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Well-formed buffer: full beats, then a last beat of 1 to 8 bytes
    task automatic send_buffer();
        int beats;
        beats = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(6, 1);
        for (int b = 1; b < beats; b++)
            send_item(random_data(), COUNT_W'(BYTES_PER_ITEM), 1'b0);
        send_item(random_data(), COUNT_W'($urandom_range(BYTES_PER_ITEM, 1)), 1'b1);
    endtask

    // Anything the fields allow: empty, odd mid-buffer, oversized counts
    task automatic send_noise();
        send_item(random_data(), COUNT_W'($urandom_range((1 << COUNT_W) - 1)),
                  1'($urandom_range(1)));
    endtask

    task automatic run_phase(input int target, input logic order, input int send_pct,
                             input int recv_pct, input press_t press);
        int start;
        logic pressed;
        write_order(order);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start   = items_sent;
        pressed = 1'b0;
        while (items_sent - start < target)
        begin
            if (!pressed && items_sent - start >= target / 2)
            begin
                pressed = 1'b1;
                if (press == PRESS_DRAIN)
                    wait_results();
                else if (press == PRESS_HOLD)
                    hold_requests <= hold_requests + 1;
            end
            if ($urandom_range(9) == 0)
                send_noise();
            else
                send_buffer();
        end
    endtask

    // Stimulus
    initial
    begin
        in_valid       <= 1'b0;
        data_bytes     <= '0;
        valid_bytes    <= '0;
        last           <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= 1'b0;
        rst_n          <= 1'b0;
        hold_requests  <= 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, network order from reset: extremes and corner counts
        send_item('1, 4'd8, 1'b0);
        send_item('1, 4'd8, 1'b1);
        send_item('0, 4'd8, 1'b1);
        send_item(64'h0123_4567_89ab_cdef, 4'd3, 1'b1);   // odd final byte
        send_item(64'hffff_ffff_ffff_ffa5, 4'd1, 1'b1);   // single byte buffer
        send_item('1, 4'd0, 1'b1);                        // empty last beat still emits
        send_item('1, 4'd0, 1'b0);
        send_item(64'h8000_0001_8000_0001, 4'd8, 1'b1);
        send_item('1, 4'd9, 1'b0);                        // oversized counts saturate
        send_item(64'hfedc_ba98_7654_3210, 4'd15, 1'b1);
        send_item(64'h1122_3344_5566_7788, 4'd5, 1'b0);   // odd count mid-buffer
        send_item(64'h99aa_bbcc_ddee_ff00, 4'd7, 1'b1);

        // Directed, host order
        write_order(1'b0);
        send_item(64'h0000_0000_0000_00c3, 4'd1, 1'b1);
        send_item(64'h0123_4567_89ab_cdef, 4'd3, 1'b1);
        send_item('1, 4'd8, 1'b0);
        send_item('1, 4'd8, 1'b1);
        send_item(64'h1122_3344_5566_7788, 4'd5, 1'b0);
        send_item(64'h8000_0001_8000_0001, 4'd12, 1'b1);
        send_item('0, 4'd0, 1'b1);

        // Random phases with different idling mixes and byte orders
        run_phase(380, 1'b1, 16, 80, PRESS_DRAIN);
        run_phase(380, 1'b0, 80, 16, PRESS_DRAIN);
        run_phase(380, 1'b1, 0, 0, PRESS_HOLD);

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_sums.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
